// ===== sv/jpeg_frame_size_scanner_top_defines.svh =====
// Assertion macros used by the frame size scanner checker.
`ifndef JPEG_FRAME_SIZE_SCANNER_TOP_DEFINES_SVH
`define JPEG_FRAME_SIZE_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JFSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jfss check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JFSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jfss check failed");

`endif

// ===== sv/jfss_pkg.sv =====
// Types and constants of the JPEG frame size scanner.
package jfss_pkg;

    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_SOF0   = 8'hC0;
    localparam logic [7:0] SOF_COUNT   = 8'd3;
    localparam logic [15:0] SEG_LEN_MIN = 16'd2;
    localparam logic [15:0] SOF_LEN_MIN = 16'd5;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_JPEG  = 3'd1,
        ST_NO_PREFIX = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_TRUNC     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_START0  = 4'd0,
        PH_START1  = 4'd1,
        PH_START2  = 4'd2,
        PH_MARKER  = 4'd3,
        PH_LEN_HI  = 4'd4,
        PH_LEN_LO  = 4'd5,
        PH_SKIP    = 4'd6,
        PH_PREFIX  = 4'd7,
        PH_SOFL_HI = 4'd8,
        PH_SOFL_LO = 4'd9,
        PH_PREC    = 4'd10,
        PH_H_HI    = 4'd11,
        PH_H_LO    = 4'd12,
        PH_W_HI    = 4'd13,
        PH_W_LO    = 4'd14
    } phase_t;

    typedef struct packed {
        logic        hit;
        status_t     status;
        logic [15:0] width;
        logic [15:0] height;
    } parse_result_t;

endpackage

// ===== sv/jfss_parser.sv =====
// Marker walker: parse state registers and the per-beat result it yields.
module jfss_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_file,
    output jfss_pkg::parse_result_t result
);

    jfss_pkg::phase_t phase_reg, phase_next;
    logic             done_reg, done_next;
    logic [15:0]      skip_reg, skip_next;
    logic [15:0]      accum_reg, accum_next;
    logic [15:0]      height_reg, height_next;

    logic [15:0]      len_full;
    logic [15:0]      skip_dec;
    logic             is_sof;
    logic             fail;
    jfss_pkg::status_t fail_code;
    logic             ok;

    assign len_full = {accum_reg[15:8], data_byte};
    assign skip_dec = skip_reg - 16'd1;
    assign is_sof   = (data_byte - jfss_pkg::MARK_SOF0) < jfss_pkg::SOF_COUNT;

    // Parse step: phase advance and error detection.
    always_comb
    begin
        phase_next = phase_reg;
        fail       = 1'b0;
        fail_code  = jfss_pkg::ST_NOT_JPEG;
        ok         = 1'b0;
        case (phase_reg)
            jfss_pkg::PH_START0:
            begin
                if (data_byte == jfss_pkg::MARK_PREFIX) phase_next = jfss_pkg::PH_START1;
                else fail = 1'b1;
            end
            jfss_pkg::PH_START1:
            begin
                if (data_byte == jfss_pkg::MARK_SOI) phase_next = jfss_pkg::PH_START2;
                else fail = 1'b1;
            end
            jfss_pkg::PH_START2:
            begin
                if (data_byte == jfss_pkg::MARK_PREFIX) phase_next = jfss_pkg::PH_MARKER;
                else fail = 1'b1;
            end
            jfss_pkg::PH_MARKER:
                phase_next = is_sof ? jfss_pkg::PH_SOFL_HI : jfss_pkg::PH_LEN_HI;
            jfss_pkg::PH_LEN_HI:
                phase_next = jfss_pkg::PH_LEN_LO;
            jfss_pkg::PH_LEN_LO:
            begin
                if (len_full < jfss_pkg::SEG_LEN_MIN)
                begin
                    fail      = 1'b1;
                    fail_code = jfss_pkg::ST_BAD_LEN;
                end
                else if (len_full == jfss_pkg::SEG_LEN_MIN)
                    phase_next = jfss_pkg::PH_PREFIX;
                else
                    phase_next = jfss_pkg::PH_SKIP;
            end
            jfss_pkg::PH_SKIP:
            begin
                if (skip_dec == 16'd0) phase_next = jfss_pkg::PH_PREFIX;
            end
            jfss_pkg::PH_PREFIX:
            begin
                if (data_byte == jfss_pkg::MARK_PREFIX) phase_next = jfss_pkg::PH_MARKER;
                else
                begin
                    fail      = 1'b1;
                    fail_code = jfss_pkg::ST_NO_PREFIX;
                end
            end
            jfss_pkg::PH_SOFL_HI: phase_next = jfss_pkg::PH_SOFL_LO;
            jfss_pkg::PH_SOFL_LO: phase_next = jfss_pkg::PH_PREC;
            jfss_pkg::PH_PREC:
            begin
                if (accum_reg < jfss_pkg::SOF_LEN_MIN)
                begin
                    fail      = 1'b1;
                    fail_code = jfss_pkg::ST_BAD_LEN;
                end
                else
                    phase_next = jfss_pkg::PH_H_HI;
            end
            jfss_pkg::PH_H_HI: phase_next = jfss_pkg::PH_H_LO;
            jfss_pkg::PH_H_LO: phase_next = jfss_pkg::PH_W_HI;
            jfss_pkg::PH_W_HI: phase_next = jfss_pkg::PH_W_LO;
            jfss_pkg::PH_W_LO: ok = 1'b1;
            default:           fail = 1'b1;
        endcase
    end

    // Result and datapath updates.
    always_comb
    begin
        result.hit    = 1'b0;
        result.status = jfss_pkg::ST_OK;
        result.width  = 16'd0;
        result.height = 16'd0;
        skip_next     = skip_reg;
        accum_next    = accum_reg;
        height_next   = height_reg;
        case (phase_reg)
            jfss_pkg::PH_LEN_HI,
            jfss_pkg::PH_SOFL_HI,
            jfss_pkg::PH_W_HI:   accum_next = {data_byte, 8'd0};
            jfss_pkg::PH_LEN_LO: begin
                accum_next = len_full;
                skip_next  = len_full - jfss_pkg::SEG_LEN_MIN;
            end
            jfss_pkg::PH_SOFL_LO: accum_next = len_full;
            jfss_pkg::PH_SKIP:    skip_next = skip_dec;
            jfss_pkg::PH_H_HI:    height_next = {data_byte, 8'd0};
            jfss_pkg::PH_H_LO:    height_next = {height_reg[15:8], data_byte};
            default:              accum_next = accum_reg;
        endcase
        if (!done_reg)
        begin
            if (ok)
            begin
                result.hit    = 1'b1;
                result.width  = len_full;
                result.height = height_reg;
            end
            else if (fail)
            begin
                result.hit    = 1'b1;
                result.status = fail_code;
            end
            else if (end_of_file)
            begin
                result.hit    = 1'b1;
                result.status = jfss_pkg::ST_TRUNC;
            end
        end
        // Rearm on the end flag; drain after a mid-file result.
        if (end_of_file) done_next = 1'b0;
        else             done_next = done_reg | result.hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jfss_pkg::PH_START0;
            done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            done_reg <= done_next;
            if (end_of_file || result.hit || done_reg)
                phase_reg <= jfss_pkg::PH_START0;
            else
                phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !done_reg)
        begin
            skip_reg   <= skip_next;
            accum_reg  <= accum_next;
            height_reg <= height_next;
        end
    end

endmodule

// ===== sv/jpeg_frame_size_scanner_top.sv =====
// Latency: a result beat appears on the cycle after the byte that decides it.
// Throughput: one byte per cycle; the input stalls only while a result is held
// and the output is stalled.
// Reset: rst_n clears the parse phase, the drain flag and the result valid at
// once; the block then expects the FF of a new file.
// Top level of the JPEG frame size scanner.
module jpeg_frame_size_scanner_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] image_width,
    output logic [15:0] image_height
);

    jfss_pkg::parse_result_t result;

    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic        out_free;
    logic        accept;

    // The result register frees when empty or when its beat is taken this cycle,
    // so a new byte can enter alongside a departing result.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !out_free;
    assign accept   = in_valid && out_free;

    // Parse state lives in the parser; every accepted beat steps it once.
    jfss_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .result      (result)
    );

    // Result register: load on a deciding beat, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && result.hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload holds while stalled; loads only with a new result.
    always_ff @(posedge clk)
    begin
        if (accept && result.hit)
        begin
            status_reg <= result.status;
            width_reg  <= result.width;
            height_reg <= result.height;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign image_width  = width_reg;
    assign image_height = height_reg;

endmodule

// ===== sv/jfss_checker.sv =====
// Port-level checker for the frame size scanner, bound to the top level.
`include "jpeg_frame_size_scanner_top_defines.svh"

module jfss_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  data_byte,
    input logic        end_of_file,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [15:0] image_width,
    input logic [15:0] image_height
);

    `JFSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(image_width) && $stable(image_height))
    `JFSS_ASSERT_NOW(a_stall_when_full, out_valid && out_stall, in_stall)
    `JFSS_ASSERT_NOW(a_dims_zero_on_error, out_valid && status != jfss_pkg::ST_OK, image_width == 16'd0 && image_height == 16'd0)
    `JFSS_ASSERT_NOW(a_status_range, out_valid, status == jfss_pkg::ST_OK || status == jfss_pkg::ST_NOT_JPEG || status == jfss_pkg::ST_NO_PREFIX || status == jfss_pkg::ST_BAD_LEN || status == jfss_pkg::ST_TRUNC)

endmodule

bind jpeg_frame_size_scanner_top jfss_checker u_jfss_checker (.*);

// ===== dv/frame_size_checker.sv =====
`timescale 1ns / 100ps
// Watches both channels of the frame size scanner, predicts each result and compares it.
module frame_size_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [15:0] image_width,
    input  logic [15:0] image_height,
    output int          mismatches,
    output int          results_due
);

    typedef struct packed {
        jfss_pkg::status_t status;
        logic [15:0]       width;
        logic [15:0]       height;
    } frame_dims_t;

    // Shadow copy of the parser state.
    jfss_pkg::phase_t phase;
    logic [15:0]      skip_left;
    logic [15:0]      field_acc;
    logic [15:0]      height_acc;
    logic             draining;

    frame_dims_t dims_due_q[$];
    int          mismatch_count = 0;

    assign mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0d ns: %s", $time, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic rearm_parser();
        phase      = jfss_pkg::PH_START0;
        skip_left  = '0;
        field_acc  = '0;
        height_acc = '0;
        draining   = 1'b0;
    endtask

    // Advance the parser by one byte; hit says whether a result beat follows.
    task automatic scan_byte(input logic [7:0] b, input logic last,
                             output logic hit, output frame_dims_t res);
        logic decided;
        decided    = 1'b0;
        hit        = 1'b0;
        res.status = jfss_pkg::ST_OK;
        res.width  = '0;
        res.height = '0;
        if (draining) begin
            if (last)
                rearm_parser();
        end
        else begin
            case (phase)
                jfss_pkg::PH_START0:
                    if (b == jfss_pkg::MARK_PREFIX) phase = jfss_pkg::PH_START1;
                    else begin decided = 1'b1; res.status = jfss_pkg::ST_NOT_JPEG; end
                jfss_pkg::PH_START1:
                    if (b == jfss_pkg::MARK_SOI) phase = jfss_pkg::PH_START2;
                    else begin decided = 1'b1; res.status = jfss_pkg::ST_NOT_JPEG; end
                jfss_pkg::PH_START2:
                    if (b == jfss_pkg::MARK_PREFIX) phase = jfss_pkg::PH_MARKER;
                    else begin decided = 1'b1; res.status = jfss_pkg::ST_NOT_JPEG; end
                jfss_pkg::PH_MARKER:
                    if (8'(b - jfss_pkg::MARK_SOF0) < jfss_pkg::SOF_COUNT)
                        phase = jfss_pkg::PH_SOFL_HI;
                    else
                        phase = jfss_pkg::PH_LEN_HI;
                jfss_pkg::PH_LEN_HI: begin
                    field_acc = {b, 8'h00};
                    phase     = jfss_pkg::PH_LEN_LO;
                end
                jfss_pkg::PH_LEN_LO: begin
                    field_acc = {field_acc[15:8], b};
                    if (field_acc < jfss_pkg::SEG_LEN_MIN) begin
                        decided    = 1'b1;
                        res.status = jfss_pkg::ST_BAD_LEN;
                    end
                    else begin
                        skip_left = field_acc - jfss_pkg::SEG_LEN_MIN;
                        if (skip_left == 16'd0) phase = jfss_pkg::PH_PREFIX;
                        else phase = jfss_pkg::PH_SKIP;
                    end
                end
                jfss_pkg::PH_SKIP: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'd0) phase = jfss_pkg::PH_PREFIX;
                end
                jfss_pkg::PH_PREFIX:
                    if (b == jfss_pkg::MARK_PREFIX) phase = jfss_pkg::PH_MARKER;
                    else begin decided = 1'b1; res.status = jfss_pkg::ST_NO_PREFIX; end
                jfss_pkg::PH_SOFL_HI: begin
                    field_acc = {b, 8'h00};
                    phase     = jfss_pkg::PH_SOFL_LO;
                end
                jfss_pkg::PH_SOFL_LO: begin
                    field_acc = {field_acc[15:8], b};
                    phase     = jfss_pkg::PH_PREC;
                end
                jfss_pkg::PH_PREC:
                    if (field_acc < jfss_pkg::SOF_LEN_MIN) begin
                        decided    = 1'b1;
                        res.status = jfss_pkg::ST_BAD_LEN;
                    end
                    else phase = jfss_pkg::PH_H_HI;
                jfss_pkg::PH_H_HI: begin
                    height_acc = {b, 8'h00};
                    phase      = jfss_pkg::PH_H_LO;
                end
                jfss_pkg::PH_H_LO: begin
                    height_acc = {height_acc[15:8], b};
                    phase      = jfss_pkg::PH_W_HI;
                end
                jfss_pkg::PH_W_HI: begin
                    field_acc = {b, 8'h00};
                    phase     = jfss_pkg::PH_W_LO;
                end
                jfss_pkg::PH_W_LO: begin
                    field_acc  = {field_acc[15:8], b};
                    decided    = 1'b1;
                    res.status = jfss_pkg::ST_OK;
                    res.width  = field_acc;
                    res.height = height_acc;
                end
                default: begin
                    decided    = 1'b1;
                    res.status = jfss_pkg::ST_NOT_JPEG;
                end
            endcase
            if (!decided && last) begin
                decided    = 1'b1;
                res.status = jfss_pkg::ST_TRUNC;
            end
            if (decided) begin
                hit = 1'b1;
                if (last) begin
                    rearm_parser();
                end
                else begin
                    draining = 1'b1;
                    phase    = jfss_pkg::PH_START0;
                end
            end
        end
    endtask

    // Retire the result beat first: it always belongs to an earlier byte.
    always @(posedge clk or negedge rst_n) begin : watch
        logic        hit;
        frame_dims_t want;
        if (!rst_n) begin
            rearm_parser();
            dims_due_q.delete();
            results_due <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (dims_due_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end
                else begin
                    want = dims_due_q.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  status, want.status));
                    if (image_width !== want.width)
                        report_mismatch($sformatf("width got %0d want %0d",
                                                  image_width, want.width));
                    if (image_height !== want.height)
                        report_mismatch($sformatf("height got %0d want %0d",
                                                  image_height, want.height));
                end
            end
            if (in_valid && !in_stall) begin
                scan_byte(data_byte, end_of_file, hit, want);
                if (hit)
                    dims_due_q.push_back(want);
            end
            results_due <= dims_due_q.size();
        end
    end

endmodule

// ===== dv/tb_jpeg_frame_size_scanner_top.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the JPEG frame size scanner, checked beside the block.
module tb_jpeg_frame_size_scanner_top;

    // Live bytes to send in the random part; trailing pad bytes do not count.
    localparam int ITEM_TARGET  = 1800;
    // Worst case is far below this: every byte and every result waiting the longest gap draw_wait gives.
    localparam int LIMIT_CYCLES = 400000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte    = 8'h00;
    logic        end_of_file  = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [2:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;

    int          fail_count;
    int          results_due;
    int unsigned cycle_count  = 0;

    // When set, both sides run flat out with no idle cycles.
    logic        calm         = 1'b0;

    // Bytes of the file being built, sent front to back; the last one carries end_of_file.
    logic [7:0]  byte_q[$];

    jpeg_frame_size_scanner_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_file  (end_of_file),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .image_width  (image_width),
        .image_height (image_height)
    );

    frame_size_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_file  (end_of_file),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .image_width  (image_width),
        .image_height (image_height),
        .mismatches   (fail_count),
        .results_due  (results_due)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stop a hung run; nothing correct comes near this count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Idle count for one beat: zero in calm stretches, else zero half the time
    // and otherwise drawn at random.
    function automatic int draw_wait();
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Result side: after each accepted result beat, hold stall for a fresh
    // random count so the next beat meets a stall at any point of its file.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                hold_left = draw_wait();
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Offer one byte. Valid drops only when a gap is drawn, so back-to-back
    // beats keep it high and just swap the payload at the accepting edge.
    // Sample stall right after the edge: that is the value the edge saw.
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_file <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < byte_q.size(); i++)
            send_beat(byte_q[i], i == byte_q.size() - 1);
    endtask

    // Drop valid and hold off until every predicted result has been taken.
    // The first edge lets the count pick up the byte accepted just now.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Build a file: start bytes, up to three skipped segments with a random marker
    // each, then an SOF segment with random size fields; its SOF length is now and
    // then below five. Lengths stay small except now and then, so skips stay short on average.
    task automatic build_frame();
        logic [7:0]  mark;
        logic [15:0] seg_len;
        logic [15:0] sof_len;
        logic [15:0] dim;
        byte_q = {jfss_pkg::MARK_PREFIX, jfss_pkg::MARK_SOI, jfss_pkg::MARK_PREFIX};
        repeat ($urandom_range(0, 3))
        begin
            mark = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0)
                mark = jfss_pkg::MARK_PREFIX;
            else if (8'(mark - jfss_pkg::MARK_SOF0) < jfss_pkg::SOF_COUNT)
                mark = mark + jfss_pkg::SOF_COUNT;
            if ($urandom_range(0, 15) == 0)
                seg_len = 16'($urandom_range(10, 300));
            else
                seg_len = 16'($urandom_range(2, 9));
            byte_q.push_back(mark);
            byte_q.push_back(seg_len[15:8]);
            byte_q.push_back(seg_len[7:0]);
            repeat (seg_len - 2) byte_q.push_back(8'($urandom_range(0, 255)));
            byte_q.push_back(jfss_pkg::MARK_PREFIX);
        end
        byte_q.push_back(jfss_pkg::MARK_SOF0 + 8'($urandom_range(0, 2)));
        case ($urandom_range(0, 15))
            0, 1:          sof_len = 16'($urandom_range(0, 4));
            2:             sof_len = 16'hFFFF;
            3, 4, 5, 6:    sof_len = 16'($urandom_range(5, 20));
            default:       sof_len = 16'($urandom_range(5, 65535));
        endcase
        byte_q.push_back(sof_len[15:8]);
        byte_q.push_back(sof_len[7:0]);
        byte_q.push_back(8'($urandom_range(0, 255)));
        dim = pick_dim();
        byte_q.push_back(dim[15:8]);
        byte_q.push_back(dim[7:0]);
        dim = pick_dim();
        byte_q.push_back(dim[15:8]);
        byte_q.push_back(dim[7:0]);
    endtask

    initial
    begin : stimulus
        int live_bytes;
        int file_count;
        int cut;
        int spot;
        live_bytes = 0;
        file_count = 0;

        // Hold reset low, then release it on a clock edge and let it settle before the first file.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed files.
        // Good file: an FF marker taken as a segment with nothing to skip,
        // then SOF0 with both sizes at their maximum.
        byte_q = {jfss_pkg::MARK_PREFIX, jfss_pkg::MARK_SOI, jfss_pkg::MARK_PREFIX,
                  jfss_pkg::MARK_PREFIX, 8'h00, 8'h02,
                  jfss_pkg::MARK_PREFIX, jfss_pkg::MARK_SOF0, 8'h00, 8'h05, 8'h00,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_file();
        // Missing prefix after a segment; the flagged byte after it is drained.
        byte_q = {jfss_pkg::MARK_PREFIX, jfss_pkg::MARK_SOI, jfss_pkg::MARK_PREFIX,
                  8'hE0, 8'h00, 8'h02, 8'h12, 8'h34};
        send_file();
        // Segment length below two, decided on the flagged low byte.
        byte_q = {jfss_pkg::MARK_PREFIX, jfss_pkg::MARK_SOI, jfss_pkg::MARK_PREFIX,
                  8'hE0, 8'h00, 8'h01};
        send_file();
        // SOF length below five, decided on the flagged precision byte.
        byte_q = {jfss_pkg::MARK_PREFIX, jfss_pkg::MARK_SOI, jfss_pkg::MARK_PREFIX,
                  jfss_pkg::MARK_SOF0 + 8'd2, 8'h00, 8'h04, 8'h08};
        send_file();
        // Early end inside the start bytes.
        byte_q = {jfss_pkg::MARK_PREFIX, jfss_pkg::MARK_SOI};
        send_file();
        // Bad start on a one-byte file: the start check wins over truncation.
        byte_q = {8'h12};
        send_file();
        drain_results();

        // Random files: mostly well-formed, the rest cut short, corrupted or noise.
        while (live_bytes < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    build_frame();
                    cut = $urandom_range(1, byte_q.size() - 1);
                    while (byte_q.size() > cut) void'(byte_q.pop_back());
                end
                3, 4, 5: begin
                    build_frame();
                    spot = $urandom_range(0, byte_q.size() - 1);
                    byte_q[spot] = 8'($urandom_range(0, 255));
                end
                6, 7: begin
                    if ($urandom_range(0, 1) == 0)
                        byte_q = {};
                    else
                        byte_q = {jfss_pkg::MARK_PREFIX, jfss_pkg::MARK_SOI,
                                  jfss_pkg::MARK_PREFIX};
                    repeat ($urandom_range(1, 6))
                        byte_q.push_back(8'($urandom_range(0, 255)));
                end
                default: build_frame();
            endcase
            live_bytes = live_bytes + byte_q.size();
            // Pad some files so the result lands mid-file and the rest drains.
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 4))
                    byte_q.push_back(8'($urandom_range(0, 255)));
            send_file();
            file_count = file_count + 1;
            if (file_count % 12 == 0)
                drain_results();
        end

        // Wait out every result, then idle a little for anything stray.
        drain_results();
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
